### hw/rtl/arp_payload_address_rewriter_top_assert.svh
// assertion macros for the arp address rewriter checker
`ifndef ARP_PAYLOAD_ADDRESS_REWRITER_TOP_ASSERT_SVH
`define ARP_PAYLOAD_ADDRESS_REWRITER_TOP_ASSERT_SVH

// same-cycle implication, disabled during reset
`define ARPR_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("arpr same-cycle check failed");

// next-cycle implication, disabled during reset
`define ARPR_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("arpr next-cycle check failed");

`endif

### hw/rtl/arpr_pkg.sv
// shared constants and types for the arp address rewriter
`default_nettype none
package arpr_pkg;

  localparam int MAX_HW_ADDR_BYTES    = 8;
  localparam int MAX_PROTO_ADDR_BYTES = 4;
  localparam int HDR_BYTES            = 8;
  localparam int POS_W                = 11;
  localparam int POS_MAX              = (1 << POS_W) - 1;
  localparam int CFG_IDX_W            = 3;
  localparam int CFG_DATA_W           = 64;

  typedef enum logic [1:0] {
    VERDICT_DROP     = 2'd0,
    VERDICT_ACCEPT   = 2'd1,
    VERDICT_CONTINUE = 2'd2
  } verdict_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MANGLE_FLAGS = 3'd0,
    CFG_SRC_HW_ADDR  = 3'd1,
    CFG_SRC_IP_ADDR  = 3'd2,
    CFG_TGT_HW_ADDR  = 3'd3,
    CFG_TGT_IP_ADDR  = 3'd4,
    CFG_PASS_VERDICT = 3'd5
  } cfg_idx_t;

  typedef struct packed {
    logic [3:0]  mangle_flags;
    logic [63:0] src_hw_addr;
    logic [31:0] src_ip_addr;
    logic [63:0] tgt_hw_addr;
    logic [31:0] tgt_ip_addr;
    logic [1:0]  pass_verdict;
  } cfg_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
    verdict_t   verdict;
  } res_t;

endpackage
`default_nettype wire

### hw/rtl/arpr_ifs.sv
// valid/ready channel interfaces for the arp address rewriter
`default_nettype none
interface arpr_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] in_byte;
  logic       in_last;
  modport source (output valid, output in_byte, output in_last, input ready);
  modport sink (input valid, input in_byte, input in_last, output ready);
endinterface

interface arpr_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic [1:0] verdict;
  modport source (output valid, output out_byte, output out_last, output verdict, input ready);
  modport sink (input valid, input out_byte, input out_last, input verdict, output ready);
endinterface

interface arpr_cfg_if;
  import arpr_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface
`default_nettype wire

### hw/rtl/arp_payload_address_rewriter_top.sv
// top level of the arp address rewriter
//
//  channel  dir  payload                       request moves
//  in_ch    in   in_byte[7:0], in_last         one packet byte
//  out_ch   out  out_byte[7:0], out_last,      one rewritten byte,
//                verdict[1:0]                  verdict on the last
//  cfg_ch   in   index[2:0], data[63:0]        one register write
//
// one byte per clock while the result buffer has room; each byte passes the
// combinational rewrite logic and is registered into a two-entry result buffer
// in_ch.ready drops only when both buffer entries wait on out_ch
// cfg_ch.ready is always high
// synchronous active-low reset clears position, lengths, drop flag, buffer
`default_nettype none
module arp_payload_address_rewriter_top (
  input  logic       clk,
  input  logic       rst_n,
  arpr_in_if.sink    in_ch,
  arpr_out_if.source out_ch,
  arpr_cfg_if.sink   cfg_ch
);
  import arpr_pkg::*;

  cfg_t cfg;
  res_t core_res;
  res_t buf_res;
  logic buf_not_full;
  logic buf_not_empty;
  logic in_fire;
  logic out_fire;

  assign cfg_ch.ready = 1'b1;
  assign in_ch.ready  = buf_not_full;
  assign in_fire      = in_ch.valid & buf_not_full;
  assign out_fire     = out_ch.ready & buf_not_empty;

  arpr_cfg u_cfg (
    .clk      (clk),
    .rst_n    (rst_n),
    .wr_en    (cfg_ch.valid),
    .wr_index (cfg_ch.index),
    .wr_data  (cfg_ch.data),
    .cfg      (cfg)
  );

  arpr_core u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_fire (in_fire),
    .in_byte (in_ch.in_byte),
    .in_last (in_ch.in_last),
    .cfg     (cfg),
    .res     (core_res)
  );

  arpr_obuf u_obuf (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (in_fire),
    .din       (core_res),
    .pop       (out_fire),
    .dout      (buf_res),
    .not_full  (buf_not_full),
    .not_empty (buf_not_empty)
  );

  assign out_ch.valid    = buf_not_empty;
  assign out_ch.out_byte = buf_res.out_byte;
  assign out_ch.out_last = buf_res.out_last;
  assign out_ch.verdict  = buf_res.verdict;

endmodule
`default_nettype wire

### hw/rtl/arpr_cfg.sv
// configuration register file
`default_nettype none
module arpr_cfg (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            wr_en,
  input  logic [arpr_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [arpr_pkg::CFG_DATA_W-1:0] wr_data,
  output arpr_pkg::cfg_t                  cfg
);
  import arpr_pkg::*;

  cfg_t cfg_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.mangle_flags <= '0;
      cfg_r.src_hw_addr  <= '0;
      cfg_r.src_ip_addr  <= '0;
      cfg_r.tgt_hw_addr  <= '0;
      cfg_r.tgt_ip_addr  <= '0;
      cfg_r.pass_verdict <= VERDICT_ACCEPT;
    end else if (wr_en) begin
      unique case (cfg_idx_t'(wr_index))
        CFG_MANGLE_FLAGS: cfg_r.mangle_flags <= wr_data[3:0];
        CFG_SRC_HW_ADDR:  cfg_r.src_hw_addr  <= wr_data;
        CFG_SRC_IP_ADDR:  cfg_r.src_ip_addr  <= wr_data[31:0];
        CFG_TGT_HW_ADDR:  cfg_r.tgt_hw_addr  <= wr_data;
        CFG_TGT_IP_ADDR:  cfg_r.tgt_ip_addr  <= wr_data[31:0];
        CFG_PASS_VERDICT: cfg_r.pass_verdict <= wr_data[1:0];
        default: ;
      endcase
    end
  end

  assign cfg = cfg_r;

endmodule
`default_nettype wire

### hw/rtl/arpr_core.sv
// packet position tracking, field rewrite and verdict logic
`default_nettype none
module arpr_core (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           in_fire,
  input  logic [7:0]     in_byte,
  input  logic           in_last,
  input  arpr_pkg::cfg_t cfg,
  output arpr_pkg::res_t res
);
  import arpr_pkg::*;

  localparam int LEN_W         = POS_W + 1;
  localparam int HW_LEN_POS    = 4;
  localparam int PROTO_LEN_POS = 5;
  localparam int FLAG_SHA      = 0;
  localparam int FLAG_SIP      = 1;
  localparam int FLAG_THA      = 2;
  localparam int FLAG_TIP      = 3;

  function automatic logic [7:0] pick_hw_byte(logic [63:0] r, logic [2:0] idx);
    return r[{~idx, 3'b000} +: 8];
  endfunction

  function automatic logic [7:0] pick_ip_byte(logic [31:0] r, logic [1:0] idx);
    return r[{~idx, 3'b000} +: 8];
  endfunction

  logic [POS_W-1:0] pos_r, pos_nxt;
  logic [7:0]       hw_len_r, hw_len_nxt;
  logic [7:0]       proto_len_r, proto_len_nxt;
  logic             drop_seen_r, drop_seen_nxt;

  logic [POS_W-1:0] sha_end, sip_end, tha_end, tip_end;
  logic [POS_W-1:0] off_sha, off_sip, off_tha, off_tip;
  logic [LEN_W-1:0] pkt_len;
  logic [3:0]       flags;
  logic             hw_ok, ip_ok, drop_now, drop;
  logic [7:0]       ob;
  verdict_t         vd;

  assign flags   = cfg.mangle_flags;
  assign hw_ok   = hw_len_r <= 8'(MAX_HW_ADDR_BYTES);
  assign ip_ok   = proto_len_r <= 8'(MAX_PROTO_ADDR_BYTES);
  assign sha_end = POS_W'(HDR_BYTES) + POS_W'(hw_len_r);
  assign sip_end = sha_end + POS_W'(proto_len_r);
  assign tha_end = sip_end + POS_W'(hw_len_r);
  assign tip_end = tha_end + POS_W'(proto_len_r);
  assign off_sha = pos_r - POS_W'(HDR_BYTES);
  assign off_sip = pos_r - sha_end;
  assign off_tha = pos_r - sip_end;
  assign off_tip = pos_r - tha_end;
  assign pkt_len = {1'b0, pos_r} + LEN_W'(1);

  always_comb begin
    ob       = in_byte;
    drop_now = 1'b0;
    if (pos_r == POS_W'(HW_LEN_POS)) begin
      ob = in_byte;
    end else if (pos_r == POS_W'(PROTO_LEN_POS)) begin
      drop_now = ((flags[FLAG_SHA] | flags[FLAG_THA]) & ~hw_ok) |
                 ((flags[FLAG_SIP] | flags[FLAG_TIP]) &
                  (in_byte > 8'(MAX_PROTO_ADDR_BYTES)));
    end else if (pos_r >= POS_W'(HDR_BYTES)) begin
      if (pos_r < sha_end) begin
        if (flags[FLAG_SHA] && hw_ok) ob = pick_hw_byte(cfg.src_hw_addr, off_sha[2:0]);
      end else if (pos_r < sip_end) begin
        if (flags[FLAG_SIP] && ip_ok) ob = pick_ip_byte(cfg.src_ip_addr, off_sip[1:0]);
      end else if (pos_r < tha_end) begin
        if (flags[FLAG_THA] && hw_ok) ob = pick_hw_byte(cfg.tgt_hw_addr, off_tha[2:0]);
      end else if (pos_r < tip_end) begin
        if (flags[FLAG_TIP] && ip_ok) ob = pick_ip_byte(cfg.tgt_ip_addr, off_tip[1:0]);
      end
    end
  end

  always_comb begin
    drop = drop_seen_r | drop_now;
    if (pkt_len < LEN_W'(HDR_BYTES)) begin
      drop = drop | (|flags);
    end else begin
      drop = drop |
             (flags[FLAG_SHA] & (pkt_len < {1'b0, sha_end})) |
             (flags[FLAG_SIP] & (pkt_len < {1'b0, sip_end})) |
             (flags[FLAG_THA] & (pkt_len < {1'b0, tha_end})) |
             (flags[FLAG_TIP] & (pkt_len < {1'b0, tip_end}));
    end
    vd = VERDICT_DROP;
    if (in_last && !drop) begin
      unique case (cfg.pass_verdict)
        VERDICT_ACCEPT:   vd = VERDICT_ACCEPT;
        VERDICT_CONTINUE: vd = VERDICT_CONTINUE;
        default:          vd = VERDICT_DROP;
      endcase
    end
  end

  always_comb begin
    pos_nxt       = pos_r;
    hw_len_nxt    = hw_len_r;
    proto_len_nxt = proto_len_r;
    drop_seen_nxt = drop_seen_r;
    if (in_fire) begin
      if (pos_r == POS_W'(HW_LEN_POS)) hw_len_nxt = in_byte;
      if (pos_r == POS_W'(PROTO_LEN_POS)) proto_len_nxt = in_byte;
      if (in_last) begin
        pos_nxt       = '0;
        drop_seen_nxt = 1'b0;
      end else begin
        if (pos_r != POS_W'(POS_MAX)) pos_nxt = pos_r + POS_W'(1);
        drop_seen_nxt = drop_seen_r | drop_now;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      hw_len_r    <= '0;
      proto_len_r <= '0;
      drop_seen_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      hw_len_r    <= hw_len_nxt;
      proto_len_r <= proto_len_nxt;
      drop_seen_r <= drop_seen_nxt;
    end
  end

  assign res.out_byte = ob;
  assign res.out_last = in_last;
  assign res.verdict  = vd;

endmodule
`default_nettype wire

### hw/rtl/arpr_obuf.sv
// two-entry result buffer between core and output channel
`default_nettype none
module arpr_obuf (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           push,
  input  arpr_pkg::res_t din,
  input  logic           pop,
  output arpr_pkg::res_t dout,
  output logic           not_full,
  output logic           not_empty
);
  import arpr_pkg::*;

  res_t       mem_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign not_full   = cnt_r != 2'd2;
  assign not_empty  = cnt_r != 2'd0;
  assign dout       = mem_r[rd_ptr_r];
  assign wr_ptr_nxt = wr_ptr_r ^ push;
  assign rd_ptr_nxt = rd_ptr_r ^ pop;
  assign cnt_nxt    = cnt_r + 2'(push) - 2'(pop);

  always_ff @(posedge clk) begin
    if (push) mem_r[wr_ptr_r] <= din;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule
`default_nettype wire

### hw/rtl/arpr_checker.sv
// port-level checker for the arp address rewriter and its bind
`default_nettype none
`include "arp_payload_address_rewriter_top_assert.svh"
module arpr_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       in_valid,
  input logic       in_ready,
  input logic       out_valid,
  input logic       out_ready,
  input logic [7:0] out_byte,
  input logic       out_last,
  input logic [1:0] verdict
);
  import arpr_pkg::*;

  // verdict only carries a decision on the last byte
  `ARPR_ASSERT_IMP(a_verdict_zero_mid, clk, rst_n, out_valid && !out_last, verdict == VERDICT_DROP)
  // unused verdict code never shown
  `ARPR_ASSERT_IMP(a_verdict_code, clk, rst_n, out_valid, verdict == VERDICT_DROP || verdict == VERDICT_ACCEPT || verdict == VERDICT_CONTINUE)
  // the output is valid in the cycle after a byte is accepted
  `ARPR_ASSERT_NXT(a_in_to_out, clk, rst_n, in_valid && in_ready, out_valid)
  // stalled result holds
  `ARPR_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_byte) && $stable(out_last) && $stable(verdict))

endmodule

bind arp_payload_address_rewriter_top arpr_checker u_arpr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_ch.valid),
  .in_ready  (in_ch.ready),
  .out_valid (out_ch.valid),
  .out_ready (out_ch.ready),
  .out_byte  (out_ch.out_byte),
  .out_last  (out_ch.out_last),
  .verdict   (out_ch.verdict)
);
`default_nettype wire

### tb/tb_arpr_rewrite_checker.sv
// watches the arp rewriter channels, predicts each rewritten byte and compares
module tb_arpr_rewrite_checker (
  input  logic clk,
  input  logic rst_n,
  arpr_in_if   in_ch,
  arpr_out_if  out_ch,
  arpr_cfg_if  cfg_ch,
  output int   fail_count,
  output int   expected_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import arpr_pkg::*;

  localparam logic [1:0] PASS_UNDEFINED = 2'd3;
  localparam int PRINT_CAP = 100;

  cfg_t             regs;
  logic [POS_W-1:0] pos_q;
  logic [7:0]       hw_len_q;
  logic [7:0]       proto_len_q;
  logic             drop_q;
  res_t             rewritten_q[$];
  int               mismatches = 0;
  int               pending = 0;

  assign fail_count     = mismatches;
  assign expected_count = pending;

  task automatic report_mismatch(input string what, input int got, input int want);
    if (mismatches < PRINT_CAP)
      $display("%0t ns mismatch on %s: got %0h expected %0h", $realtime, what, got, want);
    mismatches++;
  endtask

  function automatic logic [7:0] field_byte(input logic [63:0] value, input int nbytes,
                                            input int idx);
    if (idx >= nbytes) return 8'h00;
    return 8'(value >> (8 * (nbytes - 1 - idx)));
  endfunction

  function automatic res_t rewrite_byte(input logic [7:0] b, input logic last);
    res_t       r;
    int         p;
    int         sha_end;
    int         sip_end;
    int         tha_end;
    int         tip_end;
    int         len;
    logic       hw_fits;
    logic       ip_fits;
    logic       drop;
    logic [3:0] fl;
    p       = int'(pos_q);
    fl      = regs.mangle_flags;
    hw_fits = (hw_len_q <= MAX_HW_ADDR_BYTES);
    ip_fits = (proto_len_q <= MAX_PROTO_ADDR_BYTES);
    sha_end = HDR_BYTES + int'(hw_len_q);
    sip_end = sha_end + int'(proto_len_q);
    tha_end = sip_end + int'(hw_len_q);
    tip_end = tha_end + int'(proto_len_q);
    r.out_byte = b;
    r.out_last = last;
    r.verdict  = VERDICT_DROP;
    if (p == 4) begin
      hw_len_q = b;
    end else if (p == 5) begin
      proto_len_q = b;
      if ((fl[0] || fl[2]) && hw_len_q > MAX_HW_ADDR_BYTES) drop_q = 1'b1;
      if ((fl[1] || fl[3]) && b > MAX_PROTO_ADDR_BYTES) drop_q = 1'b1;
    end else if (p >= HDR_BYTES) begin
      if (p < sha_end) begin
        if (fl[0] && hw_fits) r.out_byte = field_byte(regs.src_hw_addr, 8, p - HDR_BYTES);
      end else if (p < sip_end) begin
        if (fl[1] && ip_fits) r.out_byte = field_byte({32'd0, regs.src_ip_addr}, 4, p - sha_end);
      end else if (p < tha_end) begin
        if (fl[2] && hw_fits) r.out_byte = field_byte(regs.tgt_hw_addr, 8, p - sip_end);
      end else if (p < tip_end) begin
        if (fl[3] && ip_fits) r.out_byte = field_byte({32'd0, regs.tgt_ip_addr}, 4, p - tha_end);
      end
    end
    if (last) begin
      len  = p + 1;
      drop = drop_q;
      if (len < HDR_BYTES) begin
        if (fl != 4'd0) drop = 1'b1;
      end else begin
        if (fl[0] && len < sha_end) drop = 1'b1;
        if (fl[1] && len < sip_end) drop = 1'b1;
        if (fl[2] && len < tha_end) drop = 1'b1;
        if (fl[3] && len < tip_end) drop = 1'b1;
      end
      if (drop || regs.pass_verdict == PASS_UNDEFINED) r.verdict = VERDICT_DROP;
      else r.verdict = verdict_t'(regs.pass_verdict);
      pos_q  = '0;
      drop_q = 1'b0;
    end else if (p < POS_MAX) begin
      pos_q = pos_q + 1'b1;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    res_t want;
    if (!rst_n) begin
      regs              = '0;
      regs.pass_verdict = VERDICT_ACCEPT;
      pos_q             = '0;
      hw_len_q          = '0;
      proto_len_q       = '0;
      drop_q            = 1'b0;
      rewritten_q.delete();
    end else begin
      if (out_ch.valid && out_ch.ready) begin
        if (rewritten_q.size() == 0) begin
          report_mismatch("unrequested result byte", out_ch.out_byte, 0);
        end else begin
          want = rewritten_q.pop_front();
          if (out_ch.out_byte !== want.out_byte)
            report_mismatch("out_byte", out_ch.out_byte, want.out_byte);
          if (out_ch.out_last !== want.out_last)
            report_mismatch("out_last", out_ch.out_last, want.out_last);
          if (out_ch.verdict !== want.verdict)
            report_mismatch("verdict", out_ch.verdict, want.verdict);
        end
      end
      if (in_ch.valid && in_ch.ready)
        rewritten_q.push_back(rewrite_byte(in_ch.in_byte, in_ch.in_last));
      if (cfg_ch.valid && cfg_ch.ready) begin
        case (cfg_idx_t'(cfg_ch.index))
          CFG_MANGLE_FLAGS: regs.mangle_flags = cfg_ch.data[3:0];
          CFG_SRC_HW_ADDR:  regs.src_hw_addr  = cfg_ch.data;
          CFG_SRC_IP_ADDR:  regs.src_ip_addr  = cfg_ch.data[31:0];
          CFG_TGT_HW_ADDR:  regs.tgt_hw_addr  = cfg_ch.data;
          CFG_TGT_IP_ADDR:  regs.tgt_ip_addr  = cfg_ch.data[31:0];
          CFG_PASS_VERDICT: regs.pass_verdict = cfg_ch.data[1:0];
          default: ;
        endcase
      end
    end
    pending = rewritten_q.size();
  end

endmodule

### tb/tb_arp_payload_address_rewriter_top.sv
// stimulus, clock, reset and verdict for the arp address rewriter
module tb_arp_payload_address_rewriter_top;
  timeunit 1ns;
  timeprecision 1ps;
  import arpr_pkg::*;

  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_BYTES   = 450;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic recv_ready = 1'b0;
  int   send_idle_pct = 0;
  int   recv_stall_pct = 0;
  int   fail_count;
  int   expected_count;
  int   items_sent = 0;
  int   frames_sent = 0;
  int   settings_loaded = 0;
  int   quiet_cycles = 0;
  logic [7:0] frame_q[$];

  arpr_in_if  in_ch();
  arpr_out_if out_ch();
  arpr_cfg_if cfg_ch();

  assign out_ch.ready = recv_ready;

  arp_payload_address_rewriter_top u_top (
    .clk   (clk),
    .rst_n (rst_n),
    .in_ch (in_ch),
    .out_ch(out_ch),
    .cfg_ch(cfg_ch)
  );

  tb_arpr_rewrite_checker u_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_ch         (in_ch),
    .out_ch        (out_ch),
    .cfg_ch        (cfg_ch),
    .fail_count    (fail_count),
    .expected_count(expected_count)
  );

  always #6 clk = ~clk;

  always @(negedge clk) recv_ready <= ($urandom_range(99) >= recv_stall_pct);

  always @(posedge clk) begin
    if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready) ||
        (cfg_ch.valid && cfg_ch.ready))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("watchdog: no request moved for %0d cycles", STALL_LIMIT);
      $display("FAILURE");
      $finish;
    end
  end

  task automatic send_byte(input logic [7:0] b, input logic last);
    while ($urandom_range(99) < send_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid   <= 1'b1;
    in_ch.in_byte <= b;
    in_ch.in_last <= last;
    do @(posedge clk); while (!in_ch.ready);
    items_sent++;
    @(negedge clk);
  endtask

  task automatic hold_until_empty();
    in_ch.valid <= 1'b0;
    do @(negedge clk); while (expected_count != 0);
    repeat (2) @(negedge clk);
  endtask

  task automatic write_reg(input cfg_idx_t idx, input logic [63:0] value);
    cfg_ch.valid <= 1'b1;
    cfg_ch.index <= idx;
    cfg_ch.data  <= value;
    do @(posedge clk); while (!cfg_ch.ready);
    @(negedge clk);
  endtask

  task automatic write_flags(input logic [3:0] flags);
    write_reg(CFG_MANGLE_FLAGS, {60'd0, flags});
    cfg_ch.valid <= 1'b0;
  endtask

  task automatic load_settings(input logic [3:0] flags, input logic [63:0] shw,
                               input logic [31:0] sip, input logic [63:0] thw,
                               input logic [31:0] tip, input logic [1:0] pv);
    write_reg(CFG_MANGLE_FLAGS, {60'd0, flags});
    write_reg(CFG_SRC_HW_ADDR, shw);
    write_reg(CFG_SRC_IP_ADDR, {32'd0, sip});
    write_reg(CFG_TGT_HW_ADDR, thw);
    write_reg(CFG_TGT_IP_ADDR, {32'd0, tip});
    write_reg(CFG_PASS_VERDICT, {62'd0, pv});
    cfg_ch.valid <= 1'b0;
    settings_loaded++;
  endtask

  function automatic logic [63:0] rand_addr();
    case ($urandom_range(9))
      0:       return '0;
      1:       return '1;
      default: return {$urandom, $urandom};
    endcase
  endfunction

  task automatic pick_settings();
    logic [3:0]  fl;
    logic [63:0] shw;
    logic [63:0] sip;
    logic [63:0] thw;
    logic [63:0] tip;
    case ($urandom_range(9))
      0:       fl = 4'h0;
      1, 2:    fl = 4'hF;
      default: fl = 4'($urandom_range(15));
    endcase
    shw = rand_addr();
    sip = rand_addr();
    thw = rand_addr();
    tip = rand_addr();
    load_settings(fl, shw, sip[31:0], thw, tip[31:0], 2'($urandom_range(3)));
  endtask

  // well-formed packets mostly, then truncated, oversized lengths and noise
  task automatic make_frame();
    int kind;
    int hw;
    int pr;
    int len;
    kind = $urandom_range(99);
    frame_q.delete();
    if (kind < 75) begin
      hw  = $urandom_range(1) ? 6 : $urandom_range(MAX_HW_ADDR_BYTES);
      pr  = $urandom_range(1) ? 4 : $urandom_range(MAX_PROTO_ADDR_BYTES);
      len = HDR_BYTES + 2 * (hw + pr);
      if (kind >= 60) len = $urandom_range(1, len - 1);
      else if ($urandom_range(3) == 0) len = len + $urandom_range(1, 4);
    end else if (kind < 88) begin
      hw = $urandom_range(MAX_HW_ADDR_BYTES + 1, 255);
      pr = $urandom_range(MAX_PROTO_ADDR_BYTES);
      if ($urandom_range(1)) begin
        pr = $urandom_range(MAX_PROTO_ADDR_BYTES + 1, 255);
        if ($urandom_range(1)) hw = $urandom_range(MAX_HW_ADDR_BYTES);
      end
      len = $urandom_range(6, 48);
    end else begin
      hw  = -1;
      pr  = -1;
      len = $urandom_range(1, 24);
    end
    for (int i = 0; i < len; i++) begin
      if (i == 4 && hw >= 0) frame_q.push_back(8'(hw));
      else if (i == 5 && pr >= 0) frame_q.push_back(8'(pr));
      else frame_q.push_back(8'($urandom_range(255)));
    end
  endtask

  task automatic send_frame(input int pause_at, input logic [3:0] pause_flags);
    for (int i = 0; i < frame_q.size(); i++) begin
      if (i == pause_at) begin
        hold_until_empty();
        write_flags(pause_flags);
      end
      send_byte(frame_q[i], i == frame_q.size() - 1);
    end
    frames_sent++;
  endtask

  initial begin
    int budget;
    int pause_at;
    in_ch.valid   = 1'b0;
    in_ch.in_byte = '0;
    in_ch.in_last = 1'b0;
    cfg_ch.valid  = 1'b0;
    cfg_ch.index  = CFG_MANGLE_FLAGS;
    cfg_ch.data   = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // header cut short, no rewrite enabled
    frame_q = '{8'h00, 8'hff, 8'h5a};
    send_frame(-1, 4'h0);
    hold_until_empty();
    load_settings(4'hF, '1, '0, 64'h0123_4567_89ab_cdef, '1, VERDICT_CONTINUE);
    // one-byte addresses, all four fields rewritten
    frame_q = '{8'h00, 8'h01, 8'h08, 8'h00, 8'h01, 8'h01, 8'h00, 8'h01,
                8'hff, 8'h00, 8'h55, 8'haa};
    send_frame(-1, 4'h0);
    // header cut short with rewrites enabled
    frame_q = '{8'hff, 8'hff, 8'hff, 8'hff};
    send_frame(-1, 4'h0);
    // hw length over limit, then flags cleared mid-packet
    frame_q = '{8'h00, 8'h01, 8'h08, 8'h00, 8'h09, 8'h00, 8'h00, 8'h02};
    send_frame(6, 4'h0);

    for (int ph = 0; ph < 4; ph++) begin
      hold_until_empty();
      case (ph)
        0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
        1: begin send_idle_pct = 56; recv_stall_pct = 0;  end
        2: begin send_idle_pct = 0;  recv_stall_pct = 56; end
        default: begin send_idle_pct = 8; recv_stall_pct = 8; end
      endcase
      pick_settings();
      budget = items_sent + PHASE_BYTES;
      while (items_sent < budget) begin
        make_frame();
        pause_at = -1;
        if (frame_q.size() > 1 && $urandom_range(24) == 0)
          pause_at = $urandom_range(1, frame_q.size() - 1);
        send_frame(pause_at, 4'($urandom_range(15)));
        if ($urandom_range(7) == 0) begin
          hold_until_empty();
          pick_settings();
        end
      end
    end

    hold_until_empty();
    repeat (4) @(negedge clk);
    $display("covered %0d packets, %0d bytes, %0d register settings over four idling phases",
             frames_sent, items_sent, settings_loaded);
    $display("including short, truncated, oversized-length and random-noise packets");
    if (fail_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
